@@ rtl/deadlock_detector_macros.svh @@
// Assertion macros used by the deadlock detector datapath.
`ifndef DEADLOCK_DETECTOR_MACROS_SVH
`define DEADLOCK_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define DD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deadlock_detector: assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define DD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deadlock_detector: assertion failed");
`else
`define DD_ASSERT_IMP(label, ante, cons)
`define DD_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ rtl/dd_pkg.sv @@
// Shared constants, codes and controller/datapath interface types.
package dd_pkg;

    localparam int N_PROC     = 8;
    localparam int N_RES      = 4;
    localparam int PROC_W     = 3;
    localparam int RES_W      = 2;
    localparam int VAL_W      = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int NP_W       = 4;
    localparam int AVAIL_W    = 12;
    localparam int MASK_W     = 8;
    localparam int NUM_TOTALS = 4;
    localparam int ADDR_W     = $clog2(N_PROC * N_RES);

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_REQ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN        = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCS  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_run;
        logic sum_acc;
        logic add_acc;
        logic scan_start;
        logic set_fin;
        logic r_clear;
        logic r_step;
        logic p_step;
        logic emit_finish;
        logic emit_verdict;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic r_last;
        logic p_last;
        logic np_zero;
        logic fin_cur;
        logic req_gt;
        logic progress;
        logic out_free;
    } status_t;

    // Flat store address of one matrix element.
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [PROC_W-1:0] p,
                                                   input logic [RES_W-1:0] r);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(p) * ADDR_W'(N_RES) + ADDR_W'(r);
        return a;
    endfunction

endpackage

@@ rtl/dd_ctrl.sv @@
// Controller state machine that sequences the summing pass and the scans.
module dd_ctrl
    import dd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] mode,
    input  status_t           status,
    output logic              in_stall,
    output cmd_t              cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_ACC,
        S_SCAN_START,
        S_CHK_TEST,
        S_CHK_RD,
        S_CHK_CMP,
        S_ADD_RD,
        S_ADD_ACC,
        S_EMIT,
        S_NEXT_P,
        S_VERDICT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Items are taken only while no run is in progress.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (mode == MODE_RUN))
                begin
                    cmd.init_run = 1'b1;
                    state_next   = status.np_zero ? S_VERDICT : S_SUM_RD;
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                cmd.r_step  = 1'b1;
                cmd.p_step  = status.r_last;
                if (status.r_last && status.p_last)
                begin
                    state_next = S_SCAN_START;
                end
                else
                begin
                    state_next = S_SUM_RD;
                end
            end
            S_SCAN_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_CHK_TEST;
            end
            S_CHK_TEST:
            begin
                cmd.r_clear = 1'b1;
                state_next  = status.fin_cur ? S_NEXT_P : S_CHK_RD;
            end
            S_CHK_RD:
            begin
                state_next = S_CHK_CMP;
            end
            S_CHK_CMP:
            begin
                if (status.req_gt)
                begin
                    state_next = S_NEXT_P;
                end
                else
                begin
                    cmd.r_step = 1'b1;
                    state_next = status.r_last ? S_ADD_RD : S_CHK_RD;
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_ACC;
            end
            S_ADD_ACC:
            begin
                cmd.add_acc = 1'b1;
                cmd.r_step  = 1'b1;
                if (status.r_last)
                begin
                    cmd.set_fin = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    state_next = S_ADD_RD;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_finish = 1'b1;
                    state_next      = S_NEXT_P;
                end
            end
            S_NEXT_P:
            begin
                if (status.p_last)
                begin
                    state_next = status.progress ? S_SCAN_START : S_VERDICT;
                end
                else
                begin
                    cmd.p_step = 1'b1;
                    state_next = S_CHK_TEST;
                end
            end
            S_VERDICT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_verdict = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/dd_datapath.sv @@
// Datapath: matrix stores, available units, finished mask, counters, output register.
`include "deadlock_detector_macros.svh"

module dd_datapath
    import dd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [VAL_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [PROC_W-1:0]    proc_index,
    input  logic [RES_W-1:0]     res_index,
    input  logic [VAL_W-1:0]     element_value,
    input  logic                 out_stall,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 out_valid,
    output logic                 is_verdict,
    output logic [PROC_W-1:0]    finished_proc,
    output logic                 deadlock,
    output logic [MASK_W-1:0]    finished_mask,
    output logic                 last
);

    // Configuration registers.
    logic [VAL_W-1:0] totals_reg [NUM_TOTALS];
    logic [NP_W-1:0]  procs_reg;

    // Matrix stores with registered read ports.
    logic [VAL_W-1:0] alloc_mem [N_PROC*N_RES];
    logic [VAL_W-1:0] req_mem   [N_PROC*N_RES];
    logic [VAL_W-1:0] alloc_rd_reg;
    logic [VAL_W-1:0] req_rd_reg;

    // Run state.
    logic signed [AVAIL_W-1:0] avail_reg  [N_RES];
    logic signed [AVAIL_W-1:0] avail_next [N_RES];
    logic [N_PROC-1:0]         fin_reg;
    logic [N_PROC-1:0]         fin_next;
    logic                      progress_reg;
    logic                      progress_next;
    logic [PROC_W-1:0]         p_reg;
    logic [PROC_W-1:0]         p_next;
    logic [RES_W-1:0]          r_reg;
    logic [RES_W-1:0]          r_next;

    // Output register.
    logic              out_valid_reg;
    logic              is_verdict_reg;
    logic [PROC_W-1:0] proc_reg;
    logic              dl_reg;
    logic [MASK_W-1:0] mask_reg;
    logic              last_reg;

    logic                      load_ok;
    logic                      we_alloc;
    logic                      we_req;
    logic [ADDR_W-1:0]         waddr;
    logic [ADDR_W-1:0]         raddr;
    logic [NP_W-1:0]           np_eff;
    logic [N_PROC-1:0]         used_mask;
    logic signed [AVAIL_W-1:0] alloc_ext;
    logic signed [AVAIL_W-1:0] req_ext;
    logic                      r_last;
    logic                      out_free;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TOTALS; i++)
            begin
                totals_reg[i] <= '0;
            end
            procs_reg <= NP_W'(N_PROC);
        end
        else if (cfg_we)
        begin
            if (cfg_addr < REG_PROCS)
            begin
                totals_reg[cfg_addr[1:0] - REG_TOTAL0[1:0]] <= cfg_wdata;
            end
            else if (cfg_addr == REG_PROCS)
            begin
                procs_reg <= cfg_wdata[NP_W-1:0];
            end
        end
    end

    // Load items that address an element inside the matrices.
    assign load_ok  = in_valid && !in_stall
                      && ({1'b0, proc_index} < NP_W'(N_PROC))
                      && ({1'b0, res_index} < 3'(N_RES));
    assign we_alloc = load_ok && (mode == MODE_LOAD_ALLOC);
    assign we_req   = load_ok && (mode == MODE_LOAD_REQ);
    assign waddr    = mem_addr(proc_index, res_index);
    assign raddr    = mem_addr(p_reg, r_reg);

    // Store write and read ports.
    always_ff @(posedge clk)
    begin
        if (we_alloc)
        begin
            alloc_mem[waddr] <= element_value;
        end
        alloc_rd_reg <= alloc_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we_req)
        begin
            req_mem[waddr] <= element_value;
        end
        req_rd_reg <= req_mem[raddr];
    end

    // Process count saturates at the matrix height.
    assign np_eff = (procs_reg > NP_W'(N_PROC)) ? NP_W'(N_PROC) : procs_reg;

    always_comb
    begin
        for (int i = 0; i < N_PROC; i++)
        begin
            used_mask[i] = (NP_W'(i) < np_eff);
        end
    end

    assign alloc_ext = $signed({{(AVAIL_W-VAL_W){1'b0}}, alloc_rd_reg});
    assign req_ext   = $signed({{(AVAIL_W-VAL_W){1'b0}}, req_rd_reg});
    assign r_last    = (r_reg == RES_W'(N_RES - 1));
    assign out_free  = !out_valid_reg || !out_stall;

    // Status back to the controller.
    always_comb
    begin
        status.r_last   = r_last;
        status.p_last   = (({1'b0, p_reg} + NP_W'(1)) == np_eff);
        status.np_zero  = (np_eff == '0);
        status.fin_cur  = fin_reg[p_reg];
        status.req_gt   = (req_ext > avail_reg[r_reg]);
        status.progress = progress_reg;
        status.out_free = out_free;
    end

    // Next values of the run state.
    always_comb
    begin
        avail_next    = avail_reg;
        fin_next      = fin_reg;
        progress_next = progress_reg;
        p_next        = p_reg;
        r_next        = r_reg;
        if (cmd.init_run)
        begin
            for (int i = 0; i < N_RES; i++)
            begin
                avail_next[i] = $signed({{(AVAIL_W-VAL_W){1'b0}}, totals_reg[i]});
            end
            fin_next = '0;
            p_next   = '0;
            r_next   = '0;
        end
        if (cmd.sum_acc)
        begin
            avail_next[r_reg] = avail_reg[r_reg] - alloc_ext;
        end
        if (cmd.add_acc)
        begin
            avail_next[r_reg] = avail_reg[r_reg] + alloc_ext;
        end
        if (cmd.scan_start)
        begin
            progress_next = 1'b0;
            p_next        = '0;
        end
        if (cmd.set_fin)
        begin
            fin_next[p_reg] = 1'b1;
            progress_next   = 1'b1;
        end
        if (cmd.r_clear)
        begin
            r_next = '0;
        end
        if (cmd.r_step)
        begin
            r_next = r_last ? '0 : r_reg + RES_W'(1);
        end
        if (cmd.p_step)
        begin
            p_next = p_reg + PROC_W'(1);
        end
    end

    // Run state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_RES; i++)
            begin
                avail_reg[i] <= '0;
            end
            fin_reg      <= '0;
            progress_reg <= 1'b0;
            p_reg        <= '0;
            r_reg        <= '0;
        end
        else
        begin
            avail_reg    <= avail_next;
            fin_reg      <= fin_next;
            progress_reg <= progress_next;
            p_reg        <= p_next;
            r_reg        <= r_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_finish || cmd.emit_verdict)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded when a result is emitted.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_finish)
        begin
            is_verdict_reg <= 1'b0;
            proc_reg       <= p_reg;
            dl_reg         <= 1'b0;
            mask_reg       <= MASK_W'(fin_reg);
            last_reg       <= 1'b0;
        end
        else if (cmd.emit_verdict)
        begin
            is_verdict_reg <= 1'b1;
            proc_reg       <= '0;
            dl_reg         <= ((fin_reg & used_mask) != used_mask);
            mask_reg       <= MASK_W'(fin_reg);
            last_reg       <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_verdict    = is_verdict_reg;
    assign finished_proc = proc_reg;
    assign deadlock      = dl_reg;
    assign finished_mask = mask_reg;
    assign last          = last_reg;

    // Finished bits are only ever added within a run.
    `DD_ASSERT_NXT(a_fin_grows, !cmd.init_run, (fin_reg & $past(fin_reg)) == $past(fin_reg))
    // A result is never loaded over one that is still waiting.
    `DD_ASSERT_IMP(a_emit_free, cmd.emit_finish || cmd.emit_verdict, out_free)
    // A verdict without deadlock covers every process in use.
    `DD_ASSERT_IMP(a_verdict_mask, out_valid_reg && is_verdict_reg && !dl_reg, (mask_reg[N_PROC-1:0] & used_mask) == used_mask)

endmodule

@@ rtl/deadlock_detector.sv @@
// Top level of the deadlock detector: controller plus datapath.
//
// Input channel (in_valid/in_stall): mode 0 and 1 items write one element of
// the allocation or request matrix and give no result; mode 2 starts a run.
// Loads are taken one per cycle whenever no run is in progress.
// A run first sums the allocation columns, one element at a time, then scans
// the processes in order. Per process a scan skips one that already
// finished, stops at the first request that does not fit, or checks every
// request, adds the allocation back and marks the process finished; scans
// repeat until one finishes nothing, at most procs + 1 scans. Each element
// is read from its store through a registered read port.
// in_stall stays high for the whole run.
// Output channel (out_valid/out_stall): one result per finished process,
// then a verdict with last set. A single output register holds each result;
// while the receiver stalls, the run waits before loading the next one.
// Reset clears the totals to 0, the process count to 8, the available units
// and the finished mask; the matrix stores hold nothing defined until loaded.
// Configuration writes through cfg_we/cfg_addr/cfg_wdata take effect at once.
module deadlock_detector
    import dd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [VAL_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_W-1:0]    mode,
    input  logic [PROC_W-1:0]    proc_index,
    input  logic [RES_W-1:0]     res_index,
    input  logic [VAL_W-1:0]     element_value,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 is_verdict,
    output logic [PROC_W-1:0]    finished_proc,
    output logic                 deadlock,
    output logic [MASK_W-1:0]    finished_mask,
    output logic                 last
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    dd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // Stores, arithmetic and output register.
    dd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .proc_index    (proc_index),
        .res_index     (res_index),
        .element_value (element_value),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .is_verdict    (is_verdict),
        .finished_proc (finished_proc),
        .deadlock      (deadlock),
        .finished_mask (finished_mask),
        .last          (last)
    );

endmodule
